[sv/zuc_pkg.sv]
// Package for the ZUC-128 keystream generator: S-boxes, D constants, types.
// Depends on nothing; used by every other file but zuc_if.
`default_nettype none
package zuc_pkg;

    localparam logic [30:0] CELL_MASK = 31'h7fffffff;
    localparam int unsigned INIT_ROUNDS = 32;

    typedef logic [30:0] t_cell;
    typedef t_cell t_lfsr [16];

    typedef enum logic {
        FUNC_RESTART  = 1'b0,
        FUNC_GENERATE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_IV_HIGH  = 2'd2,
        REG_IV_LOW   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_WORK = 2'd0,
        ST_INIT = 2'd1,
        ST_LAST = 2'd2
    } t_state;

    // One round: F output and updated state
    typedef struct packed {
        logic [31:0] w;
        logic [31:0] x3;
        logic [31:0] r1;
        logic [31:0] r2;
        t_cell       fb;
    } t_round;

    function automatic logic [14:0] dconst(input logic [3:0] i);
        logic [14:0] d;
        case (i)
            4'd0: d = 15'h44d7;   4'd1: d = 15'h26bc;
            4'd2: d = 15'h626b;   4'd3: d = 15'h135e;
            4'd4: d = 15'h5789;   4'd5: d = 15'h35e2;
            4'd6: d = 15'h7135;   4'd7: d = 15'h09af;
            4'd8: d = 15'h4d78;   4'd9: d = 15'h2f13;
            4'd10: d = 15'h6bc4;  4'd11: d = 15'h1af1;
            4'd12: d = 15'h5e26;  4'd13: d = 15'h3c4d;
            4'd14: d = 15'h789a;  default: d = 15'h47ac;
        endcase
        return d;
    endfunction

    localparam logic [7:0] SBOX0 [256] = '{
    8'h3e,8'h72,8'h5b,8'h47,8'hca,8'he0,8'h00,8'h33,8'h04,8'hd1,8'h54,8'h98,8'h09,8'hb9,8'h6d,8'hcb,
    8'h7b,8'h1b,8'hf9,8'h32,8'haf,8'h9d,8'h6a,8'ha5,8'hb8,8'h2d,8'hfc,8'h1d,8'h08,8'h53,8'h03,8'h90,
    8'h4d,8'h4e,8'h84,8'h99,8'he4,8'hce,8'hd9,8'h91,8'hdd,8'hb6,8'h85,8'h48,8'h8b,8'h29,8'h6e,8'hac,
    8'hcd,8'hc1,8'hf8,8'h1e,8'h73,8'h43,8'h69,8'hc6,8'hb5,8'hbd,8'hfd,8'h39,8'h63,8'h20,8'hd4,8'h38,
    8'h76,8'h7d,8'hb2,8'ha7,8'hcf,8'hed,8'h57,8'hc5,8'hf3,8'h2c,8'hbb,8'h14,8'h21,8'h06,8'h55,8'h9b,
    8'he3,8'hef,8'h5e,8'h31,8'h4f,8'h7f,8'h5a,8'ha4,8'h0d,8'h82,8'h51,8'h49,8'h5f,8'hba,8'h58,8'h1c,
    8'h4a,8'h16,8'hd5,8'h17,8'ha8,8'h92,8'h24,8'h1f,8'h8c,8'hff,8'hd8,8'hae,8'h2e,8'h01,8'hd3,8'had,
    8'h3b,8'h4b,8'hda,8'h46,8'heb,8'hc9,8'hde,8'h9a,8'h8f,8'h87,8'hd7,8'h3a,8'h80,8'h6f,8'h2f,8'hc8,
    8'hb1,8'hb4,8'h37,8'hf7,8'h0a,8'h22,8'h13,8'h28,8'h7c,8'hcc,8'h3c,8'h89,8'hc7,8'hc3,8'h96,8'h56,
    8'h07,8'hbf,8'h7e,8'hf0,8'h0b,8'h2b,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'ha6,8'h4c,8'h10,8'hfe,
    8'hbc,8'h26,8'h95,8'h88,8'h8a,8'hb0,8'ha3,8'hfb,8'hc0,8'h18,8'h94,8'hf2,8'he1,8'he5,8'he9,8'h5d,
    8'hd0,8'hdc,8'h11,8'h66,8'h64,8'h5c,8'hec,8'h59,8'h42,8'h75,8'h12,8'hf5,8'h74,8'h9c,8'haa,8'h23,
    8'h0e,8'h86,8'hab,8'hbe,8'h2a,8'h02,8'he7,8'h67,8'he6,8'h44,8'ha2,8'h6c,8'hc2,8'h93,8'h9f,8'hf1,
    8'hf6,8'hfa,8'h36,8'hd2,8'h50,8'h68,8'h9e,8'h62,8'h71,8'h15,8'h3d,8'hd6,8'h40,8'hc4,8'he2,8'h0f,
    8'h8e,8'h83,8'h77,8'h6b,8'h25,8'h05,8'h3f,8'h0c,8'h30,8'hea,8'h70,8'hb7,8'ha1,8'he8,8'ha9,8'h65,
    8'h8d,8'h27,8'h1a,8'hdb,8'h81,8'hb3,8'ha0,8'hf4,8'h45,8'h7a,8'h19,8'hdf,8'hee,8'h78,8'h34,8'h60};

    localparam logic [7:0] SBOX1 [256] = '{
    8'h55,8'hc2,8'h63,8'h71,8'h3b,8'hc8,8'h47,8'h86,8'h9f,8'h3c,8'hda,8'h5b,8'h29,8'haa,8'hfd,8'h77,
    8'h8c,8'hc5,8'h94,8'h0c,8'ha6,8'h1a,8'h13,8'h00,8'he3,8'ha8,8'h16,8'h72,8'h40,8'hf9,8'hf8,8'h42,
    8'h44,8'h26,8'h68,8'h96,8'h81,8'hd9,8'h45,8'h3e,8'h10,8'h76,8'hc6,8'ha7,8'h8b,8'h39,8'h43,8'he1,
    8'h3a,8'hb5,8'h56,8'h2a,8'hc0,8'h6d,8'hb3,8'h05,8'h22,8'h66,8'hbf,8'hdc,8'h0b,8'hfa,8'h62,8'h48,
    8'hdd,8'h20,8'h11,8'h06,8'h36,8'hc9,8'hc1,8'hcf,8'hf6,8'h27,8'h52,8'hbb,8'h69,8'hf5,8'hd4,8'h87,
    8'h7f,8'h84,8'h4c,8'hd2,8'h9c,8'h57,8'ha4,8'hbc,8'h4f,8'h9a,8'hdf,8'hfe,8'hd6,8'h8d,8'h7a,8'heb,
    8'h2b,8'h53,8'hd8,8'h5c,8'ha1,8'h14,8'h17,8'hfb,8'h23,8'hd5,8'h7d,8'h30,8'h67,8'h73,8'h08,8'h09,
    8'hee,8'hb7,8'h70,8'h3f,8'h61,8'hb2,8'h19,8'h8e,8'h4e,8'he5,8'h4b,8'h93,8'h8f,8'h5d,8'hdb,8'ha9,
    8'had,8'hf1,8'hae,8'h2e,8'hcb,8'h0d,8'hfc,8'hf4,8'h2d,8'h46,8'h6e,8'h1d,8'h97,8'he8,8'hd1,8'he9,
    8'h4d,8'h37,8'ha5,8'h75,8'h5e,8'h83,8'h9e,8'hab,8'h82,8'h9d,8'hb9,8'h1c,8'he0,8'hcd,8'h49,8'h89,
    8'h01,8'hb6,8'hbd,8'h58,8'h24,8'ha2,8'h5f,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hb8,8'h95,8'he4,
    8'hd0,8'h91,8'hc7,8'hce,8'hed,8'h0f,8'hb4,8'h6f,8'ha0,8'hcc,8'hf0,8'h02,8'h4a,8'h79,8'hc3,8'hde,
    8'ha3,8'hef,8'hea,8'h51,8'he6,8'h6b,8'h18,8'hec,8'h1b,8'h2c,8'h80,8'hf7,8'h74,8'he7,8'hff,8'h21,
    8'h5a,8'h6a,8'h54,8'h1e,8'h41,8'h31,8'h92,8'h35,8'hc4,8'h33,8'h07,8'h0a,8'hba,8'h7e,8'h0e,8'h34,
    8'h88,8'hb1,8'h98,8'h7c,8'hf3,8'h3d,8'h60,8'h6c,8'h7b,8'hca,8'hd3,8'h1f,8'h32,8'h65,8'h04,8'h28,
    8'h64,8'hbe,8'h85,8'h9b,8'h2f,8'h59,8'h8a,8'hd7,8'hb0,8'h25,8'hac,8'haf,8'h12,8'h03,8'he2,8'hf2};

    function automatic logic [31:0] sub_bytes(input logic [31:0] x);
        return {SBOX0[x[31:24]], SBOX1[x[23:16]], SBOX0[x[15:8]], SBOX1[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] lin1(input logic [31:0] x);
        return x ^ rotl32(x, 2) ^ rotl32(x, 10) ^ rotl32(x, 18) ^ rotl32(x, 24);
    endfunction

    function automatic logic [31:0] lin2(input logic [31:0] x);
        return x ^ rotl32(x, 8) ^ rotl32(x, 14) ^ rotl32(x, 22) ^ rotl32(x, 30);
    endfunction

    function automatic t_cell rotl31(input t_cell x, input int k);
        return (x << k) | (x >> (31 - k));
    endfunction

    // Addition mod 2^31-1 with end-around carry
    function automatic t_cell add31(input t_cell a, input t_cell b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[30:0] + {30'd0, s[31]};
    endfunction

endpackage
`default_nettype wire

[sv/zuc_if.sv]
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing.
`default_nettype none
interface zuc_if #(parameter int W = 32) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/zuc_round.sv]
// One ZUC round: bit reconstruction, F, and LFSR feedback, combinational.
// Depends on zuc_pkg.
`default_nettype none
module zuc_round (
    input  var zuc_pkg::t_lfsr   i_cells,
    input  var logic [31:0]      i_r1,
    input  var logic [31:0]      i_r2,
    input  var logic             i_init,
    output var zuc_pkg::t_round  o_res
);
    logic [31:0] x0, x1, x2, w, w1, w2;
    zuc_pkg::t_cell v, extra;

    always_comb begin
        x0 = {i_cells[15][30:15], i_cells[14][15:0]};
        x1 = {i_cells[11][15:0], i_cells[9][30:15]};
        x2 = {i_cells[7][15:0], i_cells[5][30:15]};
        w  = (x0 ^ i_r1) + i_r2;
        w1 = i_r1 + x1;
        w2 = i_r2 ^ x2;
        o_res.w  = w;
        o_res.x3 = {i_cells[2][15:0], i_cells[0][30:15]};
        o_res.r1 = zuc_pkg::sub_bytes(zuc_pkg::lin1({w1[15:0], w2[31:16]}));
        o_res.r2 = zuc_pkg::sub_bytes(zuc_pkg::lin2({w2[15:0], w1[31:16]}));
        // feedback sum, init rounds add W >> 1
        extra = i_init ? w[31:1] : '0;
        v = zuc_pkg::add31(i_cells[0], zuc_pkg::rotl31(i_cells[15], 15));
        v = zuc_pkg::add31(v, zuc_pkg::rotl31(i_cells[13], 17));
        v = zuc_pkg::add31(v, zuc_pkg::rotl31(i_cells[10], 21));
        v = zuc_pkg::add31(v, zuc_pkg::rotl31(i_cells[4], 20));
        v = zuc_pkg::add31(v, zuc_pkg::rotl31(i_cells[0], 8));
        v = zuc_pkg::add31(v, extra);
        o_res.fb = (v == '0) ? zuc_pkg::CELL_MASK : v;
    end
endmodule
`default_nettype wire

[sv/zuc_cfg.sv]
// APB register file for key and IV.
// Depends on zuc_pkg.
`default_nettype none
module zuc_cfg (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          psel,
    input  var logic          penable,
    input  var logic          pwrite,
    input  var logic [4:0]    paddr,
    input  var logic [63:0]   pwdata,
    output var logic [63:0]   prdata,
    output var logic          pready,
    output var logic [127:0]  o_key,
    output var logic [127:0]  o_iv
);
    logic [63:0] r_kh, r_kl, r_ih, r_il;
    logic [1:0]  idx;
    logic        wr;

    assign pready = 1'b1;
    assign idx = paddr[4:3];
    assign wr = psel && penable && pwrite && (paddr[2:0] == 3'd0);

    // write on access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kh <= '0; r_kl <= '0; r_ih <= '0; r_il <= '0;
        end else if (wr) begin
            case (zuc_pkg::t_reg_idx'(idx))
                zuc_pkg::REG_KEY_HIGH: r_kh <= pwdata;
                zuc_pkg::REG_KEY_LOW:  r_kl <= pwdata;
                zuc_pkg::REG_IV_HIGH:  r_ih <= pwdata;
                zuc_pkg::REG_IV_LOW:   r_il <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (zuc_pkg::t_reg_idx'(idx))
            zuc_pkg::REG_KEY_HIGH: prdata = r_kh;
            zuc_pkg::REG_KEY_LOW:  prdata = r_kl;
            zuc_pkg::REG_IV_HIGH:  prdata = r_ih;
            zuc_pkg::REG_IV_LOW:   prdata = r_il;
            default:               prdata = '0;
        endcase
    end

    assign o_key = {r_kh, r_kl};
    assign o_iv  = {r_ih, r_il};
endmodule
`default_nettype wire

[sv/zuc_keystream_generator_unit.sv]
// ZUC-128 keystream generator. A generate beat (func=1) runs one cipher round
// in the cycle it is accepted and its result is registered for the output, so
// one word per cycle flows through unless the output stalls. A restart beat
// (func=0) loads the LFSR from key, D constants and IV, then runs 32
// initialization rounds plus one discarded work round on the single round unit,
// during which no input is accepted. Registers: key_high 0x00, key_low 0x08,
// iv_high 0x10, iv_low 0x18. Depends on zuc_pkg, zuc_if, zuc_round, zuc_cfg.
`default_nettype none
module zuc_keystream_generator_unit (
    input  var logic         i_clk,
    input  var logic         i_rst_n,
    zuc_if.sink              s_in,
    zuc_if.source            m_out,
    input  var logic         psel,
    input  var logic         penable,
    input  var logic         pwrite,
    input  var logic [4:0]   paddr,
    input  var logic [63:0]  pwdata,
    output var logic [63:0]  prdata,
    output var logic         pready
);
    logic [127:0]        key, iv;
    zuc_pkg::t_lfsr      r_cells, n_cells, rd_cells;
    logic [31:0]         r_r1, n_r1, r_r2, n_r2;
    zuc_pkg::t_state     r_state, n_state;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_ovalid, n_ovalid;
    logic [31:0]         r_odata, n_odata;
    zuc_pkg::t_round     rnd;
    logic                acc, gen;

    zuc_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_key(key), .o_iv(iv)
    );

    zuc_round u_round (
        .i_cells(r_cells), .i_r1(r_r1), .i_r2(r_r2),
        .i_init(r_state == zuc_pkg::ST_INIT), .o_res(rnd)
    );

    assign s_in.ready = (r_state == zuc_pkg::ST_WORK) && (!r_ovalid || m_out.ready);
    assign acc = s_in.valid && s_in.ready;
    assign gen = acc && (s_in.data[32] == zuc_pkg::FUNC_GENERATE);
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_odata;

    // next state: sequencer plus one round step
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cells  = r_cells;
        n_r1     = r_r1;
        n_r2     = r_r2;
        n_ovalid = r_ovalid && !m_out.ready;
        n_odata  = r_odata;
        for (int i = 0; i < 15; i++) rd_cells[i] = r_cells[i+1];
        rd_cells[15] = rnd.fb;
        case (r_state)
            zuc_pkg::ST_WORK: begin
                if (gen) begin
                    n_cells  = rd_cells;
                    n_r1     = rnd.r1;
                    n_r2     = rnd.r2;
                    n_ovalid = 1'b1;
                    n_odata  = s_in.data[31:0] ^ rnd.w ^ rnd.x3;
                end else if (acc) begin
                    // load key, D and IV
                    for (int i = 0; i < 16; i++) begin
                        n_cells[i] = {key[127-8*i -: 8], zuc_pkg::dconst(4'(i)),
                                      iv[127-8*i -: 8]};
                    end
                    n_r1    = '0;
                    n_r2    = '0;
                    n_cnt   = '0;
                    n_state = zuc_pkg::ST_INIT;
                end
            end
            zuc_pkg::ST_INIT: begin
                n_cells = rd_cells;
                n_r1    = rnd.r1;
                n_r2    = rnd.r2;
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == 5'(zuc_pkg::INIT_ROUNDS - 1)) n_state = zuc_pkg::ST_LAST;
            end
            zuc_pkg::ST_LAST: begin
                n_cells = rd_cells;
                n_r1    = rnd.r1;
                n_r2    = rnd.r2;
                n_state = zuc_pkg::ST_WORK;
            end
            default: n_state = zuc_pkg::ST_WORK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= zuc_pkg::ST_WORK;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_r1     <= '0;
            r_r2     <= '0;
            for (int i = 0; i < 16; i++) r_cells[i] <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_r1     <= n_r1;
            r_r2     <= n_r2;
            r_cells  <= n_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
    end

    // a restart beat never yields a result
    a_no_out_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !gen) |=> !r_ovalid || $past(r_ovalid))
        else $error("restart produced a result");
    // busy while initializing
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != zuc_pkg::ST_WORK) |-> !s_in.ready)
        else $error("input taken during init");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_out.ready) |=> r_ovalid && $stable(r_odata))
        else $error("result lost");
endmodule
`default_nettype wire

[test/zuc_keystream_generator_unit_tb.sv]
// Self-checking testbench for the ZUC-128 keystream generator unit.
// Depends on zuc_pkg, zuc_if and zuc_keystream_generator_unit; drives the APB port and both beat channels.
`timescale 1ns / 1ps
`default_nettype none
module zuc_keystream_generator_unit_tb;

    localparam int TXT_W = 32;
    localparam int IN_W = 1 + TXT_W;
    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [63:0] pwdata, prdata;
    logic pready;

    zuc_if #(.W(IN_W)) in_ch ();
    zuc_if #(.W(TXT_W)) out_ch ();

    zuc_keystream_generator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .m_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct {
        zuc_pkg::t_func func;
        logic [31:0]    text;
    } t_beat;

    t_beat       pending_q[$];
    logic [31:0] expected_words[$];
    int          mismatches;
    int          words_checked;
    int          restarts_sent;
    longint      cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          in_taken;

    // Predictor state
    logic [63:0]    key_hi_m, key_lo_m, iv_hi_m, iv_lo_m;
    zuc_pkg::t_cell cells_m[16];
    logic [31:0]    r1_m, r2_m;

    localparam logic [14:0] D_TAB[16] = '{15'h44d7, 15'h26bc, 15'h626b, 15'h135e,
        15'h5789, 15'h35e2, 15'h7135, 15'h09af, 15'h4d78, 15'h2f13, 15'h6bc4,
        15'h1af1, 15'h5e26, 15'h3c4d, 15'h789a, 15'h47ac};

    function automatic zuc_pkg::t_cell mod_add(zuc_pkg::t_cell a, zuc_pkg::t_cell b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[31]) s = {1'b0, s[30:0]} + 32'd1;
        return s[30:0];
    endfunction

    function automatic zuc_pkg::t_cell rot_cell(zuc_pkg::t_cell x, int k);
        logic [61:0] d;
        d = {x, x};
        return d[61-k -: 31];
    endfunction

    function automatic logic [31:0] rot_word(logic [31:0] x, int k);
        logic [63:0] d;
        d = {x, x};
        return d[63-k -: 32];
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] x);
        return {zuc_pkg::SBOX0[x[31:24]], zuc_pkg::SBOX1[x[23:16]],
                zuc_pkg::SBOX0[x[15:8]], zuc_pkg::SBOX1[x[7:0]]};
    endfunction

    // Shift the register once, folding extra into the feedback
    task automatic step_cells(zuc_pkg::t_cell extra);
        zuc_pkg::t_cell v;
        v = cells_m[0];
        v = mod_add(v, rot_cell(cells_m[15], 15));
        v = mod_add(v, rot_cell(cells_m[13], 17));
        v = mod_add(v, rot_cell(cells_m[10], 21));
        v = mod_add(v, rot_cell(cells_m[4], 20));
        v = mod_add(v, rot_cell(cells_m[0], 8));
        v = mod_add(v, extra);
        for (int i = 0; i < 15; i++) cells_m[i] = cells_m[i+1];
        cells_m[15] = (v == 31'd0) ? zuc_pkg::CELL_MASK : v;
    endtask

    // Bit reorganization and nonlinear function; returns W and X3, updates R1/R2
    task automatic cipher_round(output logic [31:0] w, output logic [31:0] x3);
        logic [31:0] x0, x1, x2, w1, w2, t1, t2;
        x0 = {cells_m[15][30:15], cells_m[14][15:0]};
        x1 = {cells_m[11][15:0], cells_m[9][30:15]};
        x2 = {cells_m[7][15:0], cells_m[5][30:15]};
        x3 = {cells_m[2][15:0], cells_m[0][30:15]};
        w = (x0 ^ r1_m) + r2_m;
        w1 = r1_m + x1;
        w2 = r2_m ^ x2;
        t1 = {w1[15:0], w2[31:16]};
        t2 = {w2[15:0], w1[31:16]};
        r1_m = sbox_word(t1 ^ rot_word(t1, 2) ^ rot_word(t1, 10) ^ rot_word(t1, 18)
                         ^ rot_word(t1, 24));
        r2_m = sbox_word(t2 ^ rot_word(t2, 8) ^ rot_word(t2, 14) ^ rot_word(t2, 22)
                         ^ rot_word(t2, 30));
    endtask

    task automatic reload_cipher();
        logic [31:0] w, x3;
        logic [127:0] k, v;
        k = {key_hi_m, key_lo_m};
        v = {iv_hi_m, iv_lo_m};
        for (int i = 0; i < 16; i++)
            cells_m[i] = {k[127-8*i -: 8], D_TAB[i], v[127-8*i -: 8]};
        r1_m = '0;
        r2_m = '0;
        for (int i = 0; i < zuc_pkg::INIT_ROUNDS; i++) begin
            cipher_round(w, x3);
            step_cells(w[31:1]);
        end
        cipher_round(w, x3);
        step_cells('0);
    endtask

    // Apply one accepted beat to the predictor
    task automatic predict_beat(t_beat b);
        logic [31:0] w, x3;
        if (b.func == zuc_pkg::FUNC_RESTART) begin
            reload_cipher();
        end else begin
            cipher_round(w, x3);
            step_cells('0);
            expected_words.push_back(b.text ^ w ^ x3);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // APB register write, setup then access phase
    task automatic write_reg(zuc_pkg::t_reg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            zuc_pkg::REG_KEY_HIGH: key_hi_m = value;
            zuc_pkg::REG_KEY_LOW:  key_lo_m = value;
            zuc_pkg::REG_IV_HIGH:  iv_hi_m = value;
            default:               iv_lo_m = value;
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic write_all(logic [63:0] kh, logic [63:0] kl, logic [63:0] ih,
                             logic [63:0] il);
        write_reg(zuc_pkg::REG_KEY_HIGH, kh);
        write_reg(zuc_pkg::REG_KEY_LOW, kl);
        write_reg(zuc_pkg::REG_IV_HIGH, ih);
        write_reg(zuc_pkg::REG_IV_LOW, il);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] rand_text();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffffffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_beat(zuc_pkg::t_func f, logic [31:0] t);
        t_beat b;
        b.func = f;
        b.text = t;
        pending_q.push_back(b);
        if (f == zuc_pkg::FUNC_RESTART) restarts_sent++;
    endtask

    // Let the block drain before touching registers
    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Clock and cycle counter
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: present queued beats with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
            // hold the beat until it is taken
        end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            in_ch.valid <= 1'b1;
            in_ch.data <= {pending_q[0].func, pending_q[0].text};
        end else begin
            in_ch.valid <= 1'b0;
            in_ch.data <= {1'b1, $urandom()};
        end
    end

    // Drop beats from the queue and predict on acceptance
    always @(posedge i_clk) begin
        t_beat b;
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) begin
            b = pending_q.pop_front();
            predict_beat(b);
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected text_out", out_ch.data, 32'h0);
            end else begin
                if (out_ch.data !== expected_words[0])
                    report_mismatch("text_out", out_ch.data, expected_words[0]);
                void'(expected_words.pop_front());
                words_checked++;
            end
        end
    end

    initial begin
        int phase_pct[4][2];
        int stream_len;
        phase_pct = '{'{0, 0}, '{51, 0}, '{0, 51}, '{24, 24}};
        mismatches = 0; words_checked = 0; restarts_sent = 0; cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        key_hi_m = '0; key_lo_m = '0; iv_hi_m = '0; iv_lo_m = '0;
        for (int i = 0; i < 16; i++) cells_m[i] = '0;
        r1_m = '0; r2_m = '0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: generate from all-zero reset state, then zero key/IV restart
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'h0);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'hffffffff);
        queue_beat(zuc_pkg::FUNC_RESTART, 32'h0);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'h0);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'h0);
        wait_drained();
        // All-ones key and IV; a register write only matters at the next restart
        write_all('1, '1, '1, '1);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'h0);
        queue_beat(zuc_pkg::FUNC_RESTART, 32'hffffffff);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'h0);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'haaaa5555);
        queue_beat(zuc_pkg::FUNC_RESTART, 32'h0);
        queue_beat(zuc_pkg::FUNC_RESTART, 32'h0);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'h5555aaaa);
        wait_drained();
        write_all(64'h8000000000000001, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210);
        queue_beat(zuc_pkg::FUNC_RESTART, 32'h0);
        for (int i = 0; i < 4; i++) queue_beat(zuc_pkg::FUNC_GENERATE, rand_text());
        wait_drained();

        // Random phases: new key/IV, restart, then a keystream burst with occasional restarts
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int s = 0; s < 4; s++) begin
                write_all(rand64(), rand64(), rand64(), rand64());
                queue_beat(zuc_pkg::FUNC_RESTART, $urandom());
                for (int n = 0; n < 100; n++) begin
                    if ($urandom_range(0, 49) == 0)
                        queue_beat(zuc_pkg::FUNC_RESTART, $urandom());
                    else
                        queue_beat(zuc_pkg::FUNC_GENERATE, rand_text());
                end
                stream_len = $urandom_range(0, 3);
                for (int n = 0; n < stream_len; n++)
                    queue_beat(zuc_pkg::FUNC_GENERATE, $urandom());
                wait_drained();
            end
        end
        // Finish with zero registers
        write_all('0, '0, '0, '0);
        queue_beat(zuc_pkg::FUNC_RESTART, 32'h0);
        queue_beat(zuc_pkg::FUNC_GENERATE, 32'h0);
        wait_drained();

        $display("Checked %0d keystream words across %0d restarts, four handshake mixes",
                 words_checked, restarts_sent);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
